/* design/dmsc_pkg.sv */
// Shared types, constants and helper functions of the Bayer demosaic block.
package dmsc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = 12;
  localparam int HGT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DAT_W  = 13;
  localparam int WIN_N      = 9;
  localparam int MEM_AW     = 2 + COL_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int RECIP3     = 683;
  localparam int RECIP3_SH  = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN    = 2'd0,
    REG_INTERLACED = 2'd1,
    REG_WIDTH      = 2'd2,
    REG_HEIGHT     = 2'd3
  } cfg_reg_t;

  localparam logic CMD_RAW   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [1:0] COL_RED   = 2'd0;
  localparam logic [1:0] COL_GREEN = 2'd1;
  localparam logic [1:0] COL_BLUE  = 2'd2;

  // window slots, row-major over dy,dx in {-1,0,1}
  localparam int W_UL = 0, W_UP = 1, W_UR = 2, W_LF = 3, W_CT = 4;
  localparam int W_RT = 5, W_DL = 6, W_DN = 7, W_DR = 8;

  typedef struct packed {
    logic              emit;
    logic              store;
    logic              last;
    logic [COL_W-1:0]  x;
    logic [1:0]        y;
    logic [1:0]        c_col;
    logic [1:0]        a_col;
    logic [1:0]        b_col;
    logic [WIN_N-1:0]  mask_a;
    logic [WIN_N-1:0]  mask_b;
    logic [7:0]        data;
    logic [COL_W-1:0]  wcol;
    logic [1:0]        wrow;
  } work_t;

  function automatic logic [1:0] site_colour(input logic [1:0] pat, input logic xb,
                                             input logic yb);
    logic [1:0] k;
    begin
      k = {~yb, ~xb};
      unique case ({pat, k})
        4'h0: site_colour = COL_RED;   4'h1: site_colour = COL_GREEN;
        4'h2: site_colour = COL_GREEN; 4'h3: site_colour = COL_BLUE;
        4'h4: site_colour = COL_GREEN; 4'h5: site_colour = COL_RED;
        4'h6: site_colour = COL_BLUE;  4'h7: site_colour = COL_GREEN;
        4'h8: site_colour = COL_BLUE;  4'h9: site_colour = COL_GREEN;
        4'hA: site_colour = COL_GREEN; 4'hB: site_colour = COL_RED;
        4'hC: site_colour = COL_GREEN; 4'hD: site_colour = COL_BLUE;
        4'hE: site_colour = COL_RED;   4'hF: site_colour = COL_GREEN;
        default: site_colour = COL_RED;
      endcase
    end
  endfunction

  function automatic logic [COL_W-1:0] win_col(input logic [COL_W-1:0] x,
                                               input logic [3:0] k);
    begin
      unique case (k)
        4'd0, 4'd3, 4'd6: win_col = x - COL_W'(1);
        4'd2, 4'd5, 4'd8: win_col = x + COL_W'(1);
        default:          win_col = x;
      endcase
    end
  endfunction

  function automatic logic [1:0] win_row(input logic [1:0] y, input logic [3:0] k);
    begin
      unique case (k)
        4'd0, 4'd1, 4'd2: win_row = y - 2'd1;
        4'd6, 4'd7, 4'd8: win_row = y + 2'd1;
        default:          win_row = y;
      endcase
    end
  endfunction

endpackage

/* design/dmsc_front.sv */
// Front end: configuration, stream counters and per-transaction classification.
module dmsc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [7:0]                        in_raw,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmsc_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              fifo_full,
  output logic                              fifo_push,
  output dmsc_pkg::work_t                   fifo_item
);

  logic [1:0]                   pattern_r;
  logic                         interlaced_r;
  logic [dmsc_pkg::WID_W-1:0]   width_r;
  logic [dmsc_pkg::HGT_W-1:0]   height_r;
  logic [dmsc_pkg::COL_W-1:0]   in_col_r, out_col_r;
  logic [dmsc_pkg::ROW_W-1:0]   in_row_r, out_row_r;
  logic                         in_done_r;
  logic [dmsc_pkg::HGT_W-1:0]   diff_r;

  logic [dmsc_pkg::WID_W-1:0]   w;
  logic [dmsc_pkg::HGT_W-1:0]   h;
  logic                         fire, emit, store, last, up, dn, lf, rt;
  logic [1:0]                   c_col, h_col;
  logic [dmsc_pkg::COL_W-1:0]   half, sub, wcol;
  logic [dmsc_pkg::WID_W-1:0]   in_col_inc, out_col_inc;
  logic [dmsc_pkg::HGT_W-1:0]   in_row_inc, out_row_inc;
  dmsc_pkg::work_t              it;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~fifo_full;
  assign fire      = in_valid & in_ready;

  always_comb begin
    if (width_r < dmsc_pkg::WID_W'(2)) w = dmsc_pkg::WID_W'(2);
    else if (width_r > dmsc_pkg::WID_W'(dmsc_pkg::MAX_WIDTH))
      w = dmsc_pkg::WID_W'(dmsc_pkg::MAX_WIDTH);
    else w = width_r;
    if (height_r < dmsc_pkg::HGT_W'(2)) h = dmsc_pkg::HGT_W'(2);
    else if (height_r > dmsc_pkg::HGT_W'(dmsc_pkg::MAX_HEIGHT))
      h = dmsc_pkg::HGT_W'(dmsc_pkg::MAX_HEIGHT);
    else h = height_r;
  end

  assign in_col_inc  = dmsc_pkg::WID_W'(in_col_r) + dmsc_pkg::WID_W'(1);
  assign out_col_inc = dmsc_pkg::WID_W'(out_col_r) + dmsc_pkg::WID_W'(1);
  assign in_row_inc  = dmsc_pkg::HGT_W'(in_row_r) + dmsc_pkg::HGT_W'(1);
  assign out_row_inc = dmsc_pkg::HGT_W'(out_row_r) + dmsc_pkg::HGT_W'(1);

  assign emit  = in_done_r | (diff_r >= {w, 1'b0});
  assign store = (in_command == dmsc_pkg::CMD_RAW) & ~in_done_r;
  assign last  = (out_row_inc == h) & (out_col_inc == w);
  assign up    = out_row_r != '0;
  assign dn    = out_row_inc < h;
  assign lf    = out_col_r != '0;
  assign rt    = out_col_inc < w;
  assign c_col = dmsc_pkg::site_colour(pattern_r, out_col_r[0], out_row_r[0]);
  assign h_col = dmsc_pkg::site_colour(pattern_r, ~out_col_r[0], out_row_r[0]);

  assign half = w[dmsc_pkg::COL_W:1];
  assign sub  = in_col_r - half;
  always_comb begin
    if (!interlaced_r) wcol = in_col_r;
    else if (in_col_r < half) wcol = {in_col_r[dmsc_pkg::COL_W-2:0], 1'b1};
    else wcol = {sub[dmsc_pkg::COL_W-2:0], 1'b0};
  end

  always_comb begin
    it        = '0;
    it.emit   = emit;
    it.store  = store;
    it.last   = last;
    it.x      = out_col_r;
    it.y      = out_row_r[1:0];
    it.c_col  = c_col;
    it.data   = in_raw;
    it.wcol   = wcol;
    it.wrow   = in_row_r[1:0];
    if (c_col != dmsc_pkg::COL_GREEN) begin
      it.a_col = dmsc_pkg::COL_GREEN;
      it.b_col = dmsc_pkg::COL_BLUE - c_col;
      it.mask_a[dmsc_pkg::W_UP] = up;
      it.mask_a[dmsc_pkg::W_DN] = dn;
      it.mask_a[dmsc_pkg::W_LF] = lf;
      it.mask_a[dmsc_pkg::W_RT] = rt;
      it.mask_b[dmsc_pkg::W_DR] = dn & rt;
      it.mask_b[dmsc_pkg::W_UL] = up & lf;
      it.mask_b[dmsc_pkg::W_DL] = dn & lf;
      it.mask_b[dmsc_pkg::W_UR] = up & rt;
    end else begin
      it.a_col = h_col;
      it.b_col = dmsc_pkg::COL_BLUE - h_col;
      it.mask_a[dmsc_pkg::W_RT] = rt;
      it.mask_a[dmsc_pkg::W_LF] = lf;
      it.mask_b[dmsc_pkg::W_DN] = dn;
      it.mask_b[dmsc_pkg::W_UP] = up;
    end
  end

  assign fifo_push = fire & (emit | store);
  assign fifo_item = it;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r    <= '0;
      interlaced_r <= 1'b0;
      width_r      <= dmsc_pkg::WID_W'(640);
      height_r     <= dmsc_pkg::HGT_W'(480);
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      in_done_r    <= 1'b0;
      diff_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dmsc_pkg::cfg_reg_t'(cfg_index))
        dmsc_pkg::REG_PATTERN:    pattern_r    <= cfg_data[1:0];
        dmsc_pkg::REG_INTERLACED: interlaced_r <= cfg_data[0];
        dmsc_pkg::REG_WIDTH:      width_r      <= cfg_data[dmsc_pkg::WID_W-1:0];
        dmsc_pkg::REG_HEIGHT:     height_r     <= cfg_data;
        default: ;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      in_done_r <= 1'b0;
      diff_r    <= '0;
    end else if (fire) begin
      if (emit && last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        in_done_r <= 1'b0;
        diff_r    <= '0;
      end else begin
        if (emit) begin
          if (out_col_inc >= w) begin
            out_col_r <= '0;
            out_row_r <= out_row_inc[dmsc_pkg::ROW_W-1:0];
          end else begin
            out_col_r <= out_col_inc[dmsc_pkg::COL_W-1:0];
          end
        end
        if (emit && !store) diff_r <= diff_r - dmsc_pkg::HGT_W'(1);
        else if (!emit && store) diff_r <= diff_r + dmsc_pkg::HGT_W'(1);
        if (store) begin
          if (in_col_inc >= w) begin
            in_col_r <= '0;
            if (in_row_inc >= h) begin
              in_row_r  <= '0;
              in_done_r <= 1'b1;
            end else begin
              in_row_r <= in_row_inc[dmsc_pkg::ROW_W-1:0];
            end
          end else begin
            in_col_r <= in_col_inc[dmsc_pkg::COL_W-1:0];
          end
        end
      end
    end
  end

endmodule

/* design/dmsc_fifo.sv */
// Short work queue between the front end and the back end.
module dmsc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dmsc_pkg::work_t push_item,
  output logic            full,
  input  logic            pop,
  output dmsc_pkg::work_t head,
  output logic            empty
);

  dmsc_pkg::work_t                 q_r [dmsc_pkg::FIFO_DEPTH];
  logic [dmsc_pkg::FIFO_AW-1:0]    wp_r, rp_r;
  logic [dmsc_pkg::FIFO_AW:0]      cnt_r;

  assign full  = cnt_r == (dmsc_pkg::FIFO_AW+1)'(dmsc_pkg::FIFO_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + dmsc_pkg::FIFO_AW'(1);
      if (pop)  rp_r <= rp_r + dmsc_pkg::FIFO_AW'(1);
      if (push && !pop) cnt_r <= cnt_r + (dmsc_pkg::FIFO_AW+1)'(1);
      else if (pop && !push) cnt_r <= cnt_r - (dmsc_pkg::FIFO_AW+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue underflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (dmsc_pkg::FIFO_AW+1)'(dmsc_pkg::FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

/* design/dmsc_back.sv */
// Back end: line store, 3x3 window fetch, neighbor means and output register.
module dmsc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fifo_empty,
  input  dmsc_pkg::work_t fifo_head,
  output logic            fifo_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic            out_frame_end
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SUM   = 5'b00100,
    S_CALC  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  dmsc_pkg::work_t               cur_r;
  logic [3:0]                    cnt_r;
  logic [7:0]                    mem [2**dmsc_pkg::MEM_AW];
  logic [7:0]                    rd_q_r;
  logic [7:0]                    win_r [dmsc_pkg::WIN_N];
  logic [9:0]                    sum_a_r, sum_b_r, sum_a, sum_b;
  logic [2:0]                    n_a_r, n_b_r;
  logic                          rd_en, wr_en, out_load;
  logic [dmsc_pkg::MEM_AW-1:0]   raddr;
  logic [7:0]                    mean_a, mean_b;
  logic [7:0]                    red_r, green_r, blue_r;
  logic                          last_r, out_valid_r;

  function automatic logic [7:0] mean(input logic [9:0] s, input logic [2:0] n);
    logic [19:0] p;
    begin
      p = 20'(s) * 20'(dmsc_pkg::RECIP3);
      unique case (n)
        3'd1:    mean = s[7:0];
        3'd2:    mean = s[8:1];
        3'd3:    mean = p[dmsc_pkg::RECIP3_SH +: 8];
        3'd4:    mean = s[9:2];
        default: mean = 8'd0;
      endcase
    end
  endfunction

  function automatic logic [7:0] pick(input logic [1:0] ch, input logic [1:0] cc,
                                      input logic [1:0] ca, input logic [7:0] vc,
                                      input logic [7:0] va, input logic [7:0] vb);
    begin
      if (ch == cc) pick = vc;
      else if (ch == ca) pick = va;
      else pick = vb;
    end
  endfunction

  assign fifo_pop = (state_r == S_IDLE) & ~fifo_empty;
  assign rd_en    = (state_r == S_READ) & (cnt_r < 4'(dmsc_pkg::WIN_N));
  assign raddr    = {dmsc_pkg::win_row(cur_r.y, cnt_r), dmsc_pkg::win_col(cur_r.x, cnt_r)};
  assign wr_en    = state_r == S_WRITE;
  assign out_load = (state_r == S_CALC) & (~out_valid_r | out_ready);

  always_ff @(posedge clk) begin
    if (rd_en) rd_q_r <= mem[raddr];
    if (wr_en) mem[{cur_r.wrow, cur_r.wcol}] <= cur_r.data;
  end

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int k = 0; k < dmsc_pkg::WIN_N; k++) begin
      if (cur_r.mask_a[k]) sum_a = sum_a + 10'(win_r[k]);
      if (cur_r.mask_b[k]) sum_b = sum_b + 10'(win_r[k]);
    end
  end

  assign mean_a = mean(sum_a_r, n_a_r);
  assign mean_b = mean(sum_b_r, n_b_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!fifo_empty) begin
          if (fifo_head.emit) state_nxt = S_READ;
          else if (fifo_head.store) state_nxt = S_WRITE;
        end
      end
      S_READ:  if (cnt_r == 4'(dmsc_pkg::WIN_N)) state_nxt = S_SUM;
      S_SUM:   state_nxt = S_CALC;
      S_CALC:  if (out_load) state_nxt = cur_r.store ? S_WRITE : S_IDLE;
      S_WRITE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) cur_r <= fifo_head;
    if (state_r == S_READ && cnt_r != '0) win_r[cnt_r - 4'd1] <= rd_q_r;
    if (state_r == S_SUM) begin
      sum_a_r <= sum_a;
      sum_b_r <= sum_b;
      n_a_r   <= 3'($countones(cur_r.mask_a));
      n_b_r   <= 3'($countones(cur_r.mask_b));
    end
    if (out_load) begin
      red_r   <= pick(dmsc_pkg::COL_RED, cur_r.c_col, cur_r.a_col,
                      win_r[dmsc_pkg::W_CT], mean_a, mean_b);
      green_r <= pick(dmsc_pkg::COL_GREEN, cur_r.c_col, cur_r.a_col,
                      win_r[dmsc_pkg::W_CT], mean_a, mean_b);
      blue_r  <= pick(dmsc_pkg::COL_BLUE, cur_r.c_col, cur_r.a_col,
                      win_r[dmsc_pkg::W_CT], mean_a, mean_b);
      last_r  <= cur_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_READ) cnt_r <= cnt_r + 4'd1;
      else cnt_r <= '0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_frame_end = last_r;

  a_mask_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |-> ($countones(cur_r.mask_a) >= 1 && $countones(cur_r.mask_a) <= 4
                          && $countones(cur_r.mask_b) >= 1 && $countones(cur_r.mask_b) <= 4))
    else $error("neighbor count out of range");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n) out_load |=> out_valid_r)
    else $error("computed pixel not presented");
  a_write_needs_store: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> cur_r.store)
    else $error("store write without raw byte");
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> cnt_r <= 4'(dmsc_pkg::WIN_N))
    else $error("window fetch overrun");

endmodule

/* design/bayer_bilinear_demosaic_top.sv */
// Top level of the bilinear Bayer demosaic block.
// Usage:
//  - in_* channel: one transaction per raw byte in stored order (in_command raw)
//    or a flush transaction that carries no pixel.
//  - out_* channel: one RGB pixel per transaction in raster order; out_frame_end
//    marks the last pixel of the frame.
//  - cfg_* channel: pattern, interlaced, width, height by index; always ready.
//    A write restarts the frame; write only while the block is idle.
//  - Output pixel n appears on the transaction carrying raw byte n + 2*width;
//    the last 2*width pixels are pushed out with flush transactions.
//  - Back-end work: a pixel transaction passes queue pop, nine pipelined window
//    reads, sum and mean, and then a write of its raw byte when it carries one;
//    a store-only one is popped and written, others are only popped.
//  - A 4-entry queue parts the front end from the back end; when the receiver
//    stalls the back end holds its pixel and in_ready drops once the queue fills.
//  - Reset clears counters and configuration (640x480, BGGR, progressive);
//    line store contents are not cleared and are always written before used.
module bayer_bilinear_demosaic_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [7:0]                        in_raw,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_frame_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmsc_pkg::CFG_DAT_W-1:0]    cfg_data
);

  logic            push, full, pop, empty;
  dmsc_pkg::work_t push_item, head;

  dmsc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_raw(in_raw),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fifo_full(full), .fifo_push(push), .fifo_item(push_item)
  );

  dmsc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_item(push_item), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  dmsc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .fifo_empty(empty), .fifo_head(head), .fifo_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_frame_end(out_frame_end)
  );

endmodule
